/* hdl/mau_pkg.sv */
// Shared constants, command type and the exponential lookup table for the
// Metropolis acceptance unit. No dependencies.
`default_nettype none

package mau_pkg;

    // Field and counter widths.
    localparam int ENERGY_W        = 32;
    localparam int BETA_W          = 24;
    localparam int RAND_WIDTH      = 16;
    localparam int COUNT_WIDTH     = 40;
    // Table depth must be a power of two: the index is the top bits of the fraction.
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);

    // Beta reset value, 1.0 in Q8.16.
    localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(65536);

    // Datapath widths.
    localparam int DIFF_W     = ENERGY_W + 1;
    localparam int PROD_W     = DIFF_W + BETA_W + 1;
    localparam int ZERO_SHIFT = 37;          // 32.0 in Q.32
    localparam int MAG_LO_W   = 20;
    localparam int MAG_HI_W   = ZERO_SHIFT - MAG_LO_W;
    localparam int LOG2E_W    = 25;
    localparam logic [LOG2E_W-1:0] LOG2E_Q24 = LOG2E_W'(24204406);
    localparam int PART_LO_W  = MAG_LO_W + LOG2E_W;
    localparam int PART_HI_W  = MAG_HI_W + LOG2E_W;
    localparam int SUM_W      = ZERO_SHIFT + LOG2E_W;
    localparam int Y_SHIFT    = 24;
    localparam int Y_W        = SUM_W - Y_SHIFT;
    localparam int FRAC_W     = 32;
    localparam int K_W        = Y_W - FRAC_W;
    localparam int K_LIMIT    = 63;
    localparam int ENTRY_W    = RAND_WIDTH + 1;

    // Table construction constants.
    localparam logic [63:0] LN2_Q32      = 64'd2977044472;
    localparam int          SERIES_TERMS = 24;
    localparam int          ROUND_SHIFT  = 32 - RAND_WIDTH;

    typedef logic [ENTRY_W-1:0] exp_entry_t;
    typedef exp_entry_t [EXP_TABLE_DEPTH-1:0] exp_table_t;

    // Commands from controller to datapath, one step per cycle unless decide waits.
    typedef struct packed {
        logic capture;
        logic mul;
        logic reduce;
        logic log_step;
        logic finish;
    } cmd_t;

    // 2^-(i/D) in Q1.RAND_WIDTH, from an alternating exp(-z) series in Q.32.
    function automatic exp_table_t build_exp_table();
        exp_table_t         t;
        logic [63:0]        z;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            z    = (64'(i) * LN2_Q32) / EXP_TABLE_DEPTH;
            term = 64'd1 << 32;
            sum  = $signed(term);
            for (int n = 1; n <= SERIES_TERMS; n++) begin
                term = ((term * z) >> 32) / 64'(n);
                if ((n & 1) != 0) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
            s    = $unsigned(sum);
            t[i] = ENTRY_W'((s + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

/* hdl/metropolis_acceptance_unit.sv */
// Top level of the Metropolis acceptance unit: controller and datapath.
// Depends on mau_pkg, mau_ctrl and mau_datapath.
// Each item runs the five-step sequence (capture, multiply, reduce, log,
// decide) through one shared datapath, and output valid is registered from
// the decide step. A new input beat is taken only once the last item is
// through; a stalled output beat holds the sequence in its decide step.
// Reset: rst_n clears the state machine, output valid and both counters,
// and sets beta to 1.0; no clearing pass is needed.
`default_nettype none

module metropolis_acceptance_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write channel: beta in unsigned Q8.16.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mau_pkg::BETA_W-1:0]           inv_temperature,
    // Input channel.
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [mau_pkg::ENERGY_W-1:0]  old_energy,
    input  wire logic signed [mau_pkg::ENERGY_W-1:0]  new_energy,
    input  wire logic [mau_pkg::RAND_WIDTH-1:0]       rand_fraction,
    input  wire logic                                 count_enable,
    // Output channel.
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      accept,
    output logic [mau_pkg::COUNT_WIDTH-1:0]           accepted_total,
    output logic [mau_pkg::COUNT_WIDTH-1:0]           rejected_total
);

    mau_pkg::cmd_t cmd;

    // The beta register can take a write on any cycle. Software must make sure
    // it only changes it while no item is in flight; the block does not enforce this.
    assign cfg_ready = 1'b1;

    // The controller steps one item through the datapath and holds the
    // finished beat in the output register while the receiver stalls.
    mau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath forms exp(beta*(old-new)) as a table entry shifted by
    // the integer part of the base-2 exponent and compares it with the
    // random fraction; a non-negative exponent always accepts.
    mau_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_beta       (inv_temperature),
        .old_energy     (old_energy),
        .new_energy     (new_energy),
        .rand_fraction  (rand_fraction),
        .count_enable   (count_enable),
        .accept         (accept),
        .accepted_total (accepted_total),
        .rejected_total (rejected_total)
    );

endmodule

`default_nettype wire

/* hdl/mau_ctrl.sv */
// Sequencing state machine of the Metropolis acceptance unit.
// Depends on mau_pkg for the command struct.
`default_nettype none

module mau_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output mau_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_LOG    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_LOG;
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                // Wait here until the output register can take the result.
                if (out_free) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result never overwrites one that is still waiting.
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result written while output beat pending");

    // An accepted beat starts the multiply step next cycle.
    a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MUL))
        else $error("accepted beat did not start the multiply");

    // Output valid rises only from a finish command.
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("output valid rose without a result");

endmodule

`default_nettype wire

/* hdl/mau_datapath.sv */
// Datapath of the Metropolis acceptance unit: beta register, exponent
// multiply, base-2 range reduction, table lookup and saturating counters.
// Depends on mau_pkg.
`default_nettype none

module mau_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mau_pkg::cmd_t                        cmd,
    input  wire logic                                 cfg_write,
    input  wire logic [mau_pkg::BETA_W-1:0]           cfg_beta,
    input  wire logic signed [mau_pkg::ENERGY_W-1:0]  old_energy,
    input  wire logic signed [mau_pkg::ENERGY_W-1:0]  new_energy,
    input  wire logic [mau_pkg::RAND_WIDTH-1:0]       rand_fraction,
    input  wire logic                                 count_enable,
    output logic                                      accept,
    output logic [mau_pkg::COUNT_WIDTH-1:0]           accepted_total,
    output logic [mau_pkg::COUNT_WIDTH-1:0]           rejected_total
);

    logic [mau_pkg::BETA_W-1:0]        beta_reg;
    logic signed [mau_pkg::DIFF_W-1:0] diff_reg;
    logic [mau_pkg::RAND_WIDTH-1:0]    rand_reg;
    logic                              count_reg;
    logic signed [mau_pkg::PROD_W-1:0] prod_reg;
    logic signed [mau_pkg::PROD_W-1:0] prod_next;
    logic                              nonneg_reg;
    logic                              zero_reg;
    logic [mau_pkg::PROD_W-1:0]        mag;
    logic [mau_pkg::PART_LO_W-1:0]     part_lo_reg;
    logic [mau_pkg::PART_HI_W-1:0]     part_hi_reg;
    logic [mau_pkg::SUM_W-1:0]         sum;
    logic [mau_pkg::Y_W-1:0]           y_reg;
    logic [mau_pkg::K_W-1:0]           k;
    logic [mau_pkg::IDX_W-1:0]         idx;
    logic [mau_pkg::ENTRY_W-1:0]       entry;
    logic [mau_pkg::ENTRY_W-1:0]       e_val;
    logic                              acc;
    logic                              accept_reg;
    logic [mau_pkg::COUNT_WIDTH-1:0]   acc_cnt_reg;
    logic [mau_pkg::COUNT_WIDTH-1:0]   acc_cnt_next;
    logic [mau_pkg::COUNT_WIDTH-1:0]   rej_cnt_reg;
    logic [mau_pkg::COUNT_WIDTH-1:0]   rej_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            beta_reg <= mau_pkg::BETA_RESET;
        end
        else if (cfg_write) begin
            beta_reg <= cfg_beta;
        end
    end

    // Exponent in Q.32: (old - new) * beta.
    assign prod_next = diff_reg * $signed({1'b0, beta_reg});

    // Magnitude of a negative exponent, split for two narrow multiplies.
    assign mag = $unsigned(-prod_reg);

    assign sum = {part_hi_reg, {mau_pkg::MAG_LO_W{1'b0}}} + mau_pkg::SUM_W'(part_lo_reg);

    assign k     = y_reg[mau_pkg::Y_W-1 -: mau_pkg::K_W];
    assign idx   = y_reg[mau_pkg::FRAC_W-1 -: mau_pkg::IDX_W];
    assign entry = mau_pkg::EXP_TABLE[idx];
    assign e_val = (k >= mau_pkg::K_W'(mau_pkg::K_LIMIT)) ? '0 : (entry >> k);
    assign acc   = nonneg_reg || (!zero_reg && (e_val > mau_pkg::ENTRY_W'(rand_reg)));

    always_comb
    begin
        acc_cnt_next = acc_cnt_reg;
        rej_cnt_next = rej_cnt_reg;
        if (count_reg) begin
            if (acc) begin
                if (acc_cnt_reg != '1) begin
                    acc_cnt_next = acc_cnt_reg + 1'b1;
                end
            end
            else begin
                if (rej_cnt_reg != '1) begin
                    rej_cnt_next = rej_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            diff_reg  <= $signed({old_energy[mau_pkg::ENERGY_W-1], old_energy})
                       - $signed({new_energy[mau_pkg::ENERGY_W-1], new_energy});
            rand_reg  <= rand_fraction;
            count_reg <= count_enable;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.reduce) begin
            nonneg_reg  <= !prod_reg[mau_pkg::PROD_W-1];
            zero_reg    <= |mag[mau_pkg::PROD_W-1:mau_pkg::ZERO_SHIFT];
            part_lo_reg <= mag[mau_pkg::MAG_LO_W-1:0] * mau_pkg::LOG2E_Q24;
            part_hi_reg <= mag[mau_pkg::ZERO_SHIFT-1:mau_pkg::MAG_LO_W] * mau_pkg::LOG2E_Q24;
        end
        if (cmd.log_step) begin
            y_reg <= sum[mau_pkg::SUM_W-1:mau_pkg::Y_SHIFT];
        end
        if (cmd.finish) begin
            accept_reg <= acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_cnt_reg <= '0;
            rej_cnt_reg <= '0;
        end
        else if (cmd.finish) begin
            acc_cnt_reg <= acc_cnt_next;
            rej_cnt_reg <= rej_cnt_next;
        end
    end

    // Counters change only on a finish, which waits for the output to drain,
    // so they double as the output payload.
    assign accept         = accept_reg;
    assign accepted_total = acc_cnt_reg;
    assign rejected_total = rej_cnt_reg;

endmodule

`default_nettype wire
